/* hw/rtl/ilir_pkg.sv */
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants of the indexed list engine.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INSERT_AT  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REMOVE_AT  = 3'd5,
        OP_READ_AT    = 3'd6,
        OP_WRITE_AT   = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        K_HOLD = 2'd0,
        K_INS  = 2'd1,
        K_DEL  = 2'd2,
        K_WR   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [CNT_W-1:0] at;
        t_word            word;
    } t_cell_ctrl;

endpackage

/* hw/rtl/ilir_req_if.sv */
// ----------------------------------------------------------------------------
// ilir_req_if
// Request channel of the indexed list engine.
// ----------------------------------------------------------------------------
interface ilir_req_if;
    logic                            valid;
    logic                            ready;
    logic [ilir_pkg::OP_W-1:0]       operation;
    logic signed [ilir_pkg::WORD_W-1:0] value;
    logic [ilir_pkg::CNT_W-1:0]      position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

/* hw/rtl/ilir_rsp_if.sv */
// ----------------------------------------------------------------------------
// ilir_rsp_if
// Response channel of the indexed list engine.
// ----------------------------------------------------------------------------
interface ilir_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [ilir_pkg::WORD_W-1:0] result_value;
    logic [ilir_pkg::ST_W-1:0]          status;
    logic [ilir_pkg::CNT_W-1:0]         entry_count;

    modport source (output valid, output result_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input result_value, input status,
                    input entry_count, output ready);
endinterface

/* hw/rtl/indexed_list_insert_remove_top.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Ordered list of signed words with push, pop, insert, remove, read, write.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, one word per cell; an insert or a
// remove shifts every cell at or above the index by one place in the same
// cycle, so a new request is taken every cycle while the response side
// keeps up. The response is registered and appears the cycle after the
// request transfer; the path that sets the clock is the read select across
// all DEPTH cells. The response register frees the request side as soon as
// the waiting response is taken. Entries are not cleared by reset; only the
// count and the response valid flag are, and nothing at or beyond the count
// is ever returned.
module indexed_list_insert_remove_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilir_req_if.sink    i_req,
    ilir_rsp_if.source  o_rsp
);

    ilir_pkg::t_cell_ctrl cell_ctrl;
    ilir_pkg::t_word      cell_word [ilir_pkg::DEPTH];
    ilir_pkg::t_word      cell_sel  [ilir_pkg::DEPTH];
    ilir_pkg::t_word      rd_word;

    ilir_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_rd_word (rd_word),
        .o_ctrl    (cell_ctrl)
    );

    for (genvar k = 0; k < ilir_pkg::DEPTH; k++) begin : g_cell
        ilir_pkg::t_word left_word;
        ilir_pkg::t_word right_word;

        if (k == 0) begin : g_first
            assign left_word = cell_word[k];
        end else begin : g_mid_l
            assign left_word = cell_word[k-1];
        end

        if (k == ilir_pkg::DEPTH - 1) begin : g_last
            assign right_word = cell_word[k];
        end else begin : g_mid_r
            assign right_word = cell_word[k+1];
        end

        ilir_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_index (ilir_pkg::CNT_W'(k)),
            .i_left  (left_word),
            .i_right (right_word),
            .o_word  (cell_word[k]),
            .o_sel   (cell_sel[k])
        );
    end

    // at most one cell drives a nonzero word
    always_comb begin
        rd_word = '0;
        for (int j = 0; j < ilir_pkg::DEPTH; j++) begin
            rd_word = rd_word | cell_sel[j];
        end
    end

endmodule

/* hw/rtl/ilir_cell.sv */
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot: holds a word and takes its neighbor's word on a shift.
// ----------------------------------------------------------------------------
module ilir_cell (
    input  logic                       i_clk,
    input  ilir_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ilir_pkg::CNT_W-1:0] i_index,
    input  ilir_pkg::t_word            i_left,
    input  ilir_pkg::t_word            i_right,
    output ilir_pkg::t_word            o_word,
    output ilir_pkg::t_word            o_sel
);

    ilir_pkg::t_word r_word;
    ilir_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctrl.kind)
            ilir_pkg::K_INS: begin
                if (i_index == i_ctrl.at) begin
                    n_word = i_ctrl.word;
                end else if (i_index > i_ctrl.at) begin
                    n_word = i_left;
                end
            end
            ilir_pkg::K_DEL: begin
                if (i_index >= i_ctrl.at) begin
                    n_word = i_right;
                end
            end
            ilir_pkg::K_WR: begin
                if (i_index == i_ctrl.at) begin
                    n_word = i_ctrl.word;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    // only the addressed cell drives the read bus
    assign o_sel  = (i_index == i_ctrl.at) ? r_word : '0;

endmodule

/* hw/rtl/ilir_ctrl.sv */
// ----------------------------------------------------------------------------
// ilir_ctrl
// Request decode, entry count and registered response of the list engine.
// ----------------------------------------------------------------------------
module ilir_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ilir_req_if.sink              i_req,
    ilir_rsp_if.source            o_rsp,
    input  ilir_pkg::t_word       i_rd_word,
    output ilir_pkg::t_cell_ctrl  o_ctrl
);

    logic [ilir_pkg::CNT_W-1:0] r_count;
    logic [ilir_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    ilir_pkg::t_word            r_out_value;
    ilir_pkg::t_status          r_out_status;
    logic [ilir_pkg::CNT_W-1:0] r_out_count;

    ilir_pkg::t_op              op;
    ilir_pkg::t_status          st;
    ilir_pkg::t_kind            kind;
    logic [ilir_pkg::CNT_W-1:0] at;
    logic                       is_read;
    logic                       xfer;
    ilir_pkg::t_word            res;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign xfer        = i_req.valid && i_req.ready;
    assign op          = ilir_pkg::t_op'(i_req.operation);

    always_comb begin
        st      = ilir_pkg::ST_OK;
        kind    = ilir_pkg::K_HOLD;
        at      = i_req.position;
        is_read = 1'b0;
        unique case (op)
            ilir_pkg::OP_PUSH_FRONT, ilir_pkg::OP_PUSH_BACK: begin
                at = (op == ilir_pkg::OP_PUSH_FRONT) ? '0 : r_count;
                if (r_count >= ilir_pkg::DEPTH_C) begin
                    st = ilir_pkg::ST_FULL;
                end else begin
                    kind = ilir_pkg::K_INS;
                end
            end
            ilir_pkg::OP_INSERT_AT: begin
                // index check wins over the full check
                if (i_req.position > r_count) begin
                    st = ilir_pkg::ST_BAD_INDEX;
                end else if (r_count >= ilir_pkg::DEPTH_C) begin
                    st = ilir_pkg::ST_FULL;
                end else begin
                    kind = ilir_pkg::K_INS;
                end
            end
            ilir_pkg::OP_POP_FRONT, ilir_pkg::OP_POP_BACK: begin
                at = (op == ilir_pkg::OP_POP_FRONT) ? '0 : r_count - 1'b1;
                if (r_count == '0) begin
                    st = ilir_pkg::ST_EMPTY;
                end else begin
                    kind = ilir_pkg::K_DEL;
                end
            end
            ilir_pkg::OP_REMOVE_AT: begin
                if (i_req.position >= r_count) begin
                    st = ilir_pkg::ST_BAD_INDEX;
                end else begin
                    kind = ilir_pkg::K_DEL;
                end
            end
            ilir_pkg::OP_READ_AT: begin
                if (i_req.position >= r_count) begin
                    st = ilir_pkg::ST_BAD_INDEX;
                end else begin
                    is_read = 1'b1;
                end
            end
            default: begin
                if (i_req.position >= r_count) begin
                    st = ilir_pkg::ST_BAD_INDEX;
                end else begin
                    kind = ilir_pkg::K_WR;
                end
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (kind == ilir_pkg::K_INS) begin
            n_count = r_count + 1'b1;
        end else if (kind == ilir_pkg::K_DEL) begin
            n_count = r_count - 1'b1;
        end
    end

    // removed or read word comes from the addressed cell before the shift
    assign res = (is_read || kind == ilir_pkg::K_DEL) ? i_rd_word : '0;

    assign o_ctrl.kind = xfer ? kind : ilir_pkg::K_HOLD;
    assign o_ctrl.at   = at;
    assign o_ctrl.word = i_req.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (xfer) begin
            r_out_value  <= res;
            r_out_status <= st;
            r_out_count  <= n_count;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entry_count  = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ilir_pkg::DEPTH_C)
        else $error("entry count beyond depth");

    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && st != ilir_pkg::ST_OK) |=> (r_count == $past(r_count)))
        else $error("refused request changed the count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && kind == ilir_pkg::K_INS) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && st == ilir_pkg::ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries present");

    a_resp_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |=> (r_out_count == r_count))
        else $error("response count differs from list count");

endmodule
